/* src/tmprof_pkg.sv */
// Shared types, constants and helpers of the trapezoidal motion profile.
`default_nettype none
package tmprof_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    REG_LENGTH = 2'd0,
    REG_VMAX   = 2'd1,
    REG_AMAX   = 2'd2
  } tmprof_reg_e;

  typedef enum logic [3:0] {
    D_IDLE, D_MUL, D_CMP, D_DIV_T, D_SQRT, D_DIV_A, D_DIV_B, D_DIV_C,
    D_VA, D_VB, D_PA, D_PB
  } tmprof_dstate_e;

  typedef enum logic [2:0] {
    PH_ZERO, PH_DONE, PH_ACC, PH_CRU, PH_DEC
  } tmprof_phase_e;

  typedef enum logic [1:0] {
    AC_NONE, AC_POS, AC_NEG
  } tmprof_acode_e;

  typedef struct packed {
    logic        valid;
    logic        tri_flag;
    logic [31:0] len;
    logic [31:0] amax;
    logic [31:0] t_acc;
    logic [31:0] t_tot;
    logic [32:0] cru_end;
    logic [31:0] peak;
    logic [63:0] pos0;
  } tmprof_prof_t;

  function automatic logic [31:0] sat32(input logic [63:0] x);
    sat32 = (x[63:32] != 32'd0) ? MAX32 : x[31:0];
  endfunction

endpackage
`default_nettype wire

/* src/tmprof_if.sv */
// Handshake channels of the motion profile: samples, results, configuration.
`default_nettype none
interface tmprof_sample_if;
  logic        valid;
  logic        ready;
  logic [31:0] sample_time;
  modport source (output valid, output sample_time, input ready);
  modport sink (input valid, input sample_time, output ready);
endinterface

interface tmprof_result_if;
  logic               valid;
  logic               ready;
  logic        [31:0] position;
  logic        [31:0] velocity;
  logic signed [32:0] acceleration;
  logic        [31:0] total_time;
  logic        [31:0] peak_velocity;
  logic               is_triangular;
  logic               profile_valid;
  modport source (output valid, output position, output velocity, output acceleration,
                  output total_time, output peak_velocity, output is_triangular,
                  output profile_valid, input ready);
  modport sink (input valid, input position, input velocity, input acceleration,
                input total_time, input peak_velocity, input is_triangular,
                input profile_valid, output ready);
endinterface

interface tmprof_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  reg_index;
  logic [31:0] reg_data;
  modport source (output valid, output reg_index, output reg_data, input ready);
  modport sink (input valid, input reg_index, input reg_data, output ready);
endinterface
`default_nettype wire

/* src/tmprof_div.sv */
// Restoring shift divider, one quotient bit per cycle.
`default_nettype none
module tmprof_div import tmprof_pkg::*; #(
  parameter int DVW = 64
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire logic [DVW-1:0] dividend_i,
  input  wire logic [31:0]    divisor_i,
  output logic                done_o,
  output logic [DVW-1:0]      quotient_o
);
  localparam int CW = $clog2(DVW + 1);

  logic [CW-1:0]  cnt_q, cnt_d;
  logic [DVW-1:0] quo_q, quo_d;
  logic [31:0]    rem_q, rem_d;
  logic [31:0]    dsr_q, dsr_d;
  logic           run_q, run_d;
  logic           done_q, done_d;
  logic [32:0]    shifted;

  always_comb begin
    cnt_d   = cnt_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    dsr_d   = dsr_q;
    run_d   = run_q;
    done_d  = 1'b0;
    shifted = {rem_q, quo_q[DVW-1]};
    if (start_i) begin
      cnt_d = CW'(DVW);
      quo_d = dividend_i;
      rem_d = 32'd0;
      dsr_d = divisor_i;
      run_d = 1'b1;
    end else if (run_q) begin
      if (shifted >= {1'b0, dsr_q}) begin
        rem_d = 32'(shifted - {1'b0, dsr_q});
        quo_d = {quo_q[DVW-2:0], 1'b1};
      end else begin
        rem_d = shifted[31:0];
        quo_d = {quo_q[DVW-2:0], 1'b0};
      end
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;
endmodule
`default_nettype wire

/* src/tmprof_derive.sv */
// Configuration registers and sequential derivation of the profile timings.
`default_nettype none
module tmprof_derive import tmprof_pkg::*; #(
  parameter int FRACTION_BITS = FRAC_BITS_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  tmprof_cfg_if.sink  cfg,
  output logic        busy_o,
  output tmprof_prof_t prof_o
);
  localparam int DVW = (32 + 2 * FRACTION_BITS > 64) ? 32 + 2 * FRACTION_BITS : 64;

  tmprof_dstate_e state_q, state_d;
  logic [31:0] len_q, vmax_q, amax_q;
  logic [63:0] vv_q, la_q, mul_q;
  logic        tri_q, tovf_q;
  logic [31:0] tacc_q, tcru_q, va_q, peak_q, ttot_q;
  logic [32:0] cend_q;
  logic [63:0] rad_q;
  logic [33:0] srem_q;
  logic [31:0] root_q;
  logic [4:0]  sq_cnt_q;
  tmprof_prof_t prof_q;

  logic           cfg_wr, any_zero, tri_c;
  logic           div_start, div_done;
  logic [DVW-1:0] div_dvd, div_quo;
  logic [31:0]    div_dsr, quo_sat, dc;
  logic [35:0]    sq_r, sq_trial;
  logic [33:0]    tot_sum;
  logic [31:0]    va_c;

  assign cfg_wr    = cfg.valid && cfg.ready;
  assign cfg.ready = 1'b1;
  assign any_zero  = (len_q == 32'd0) || (vmax_q == 32'd0) || (amax_q == 32'd0);
  assign tri_c     = vv_q >= la_q;
  assign quo_sat   = ((div_quo >> 32) != '0) ? MAX32 : div_quo[31:0];
  assign dc        = len_q - div_quo[31:0];
  assign sq_r      = {srem_q, rad_q[63:62]};
  assign sq_trial  = {2'b00, root_q, 2'b01};
  assign tot_sum   = {1'b0, tacc_q, 1'b0} + {2'b00, tcru_q};
  assign va_c      = sat32(mul_q >> FRACTION_BITS);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      D_IDLE:  state_d = D_IDLE;
      D_MUL:   state_d = D_CMP;
      D_CMP:   state_d = any_zero ? D_IDLE : (tri_c ? D_DIV_T : D_DIV_A);
      D_DIV_T: if (div_done) state_d = D_SQRT;
      D_SQRT:  if (sq_cnt_q == 5'd31) state_d = D_VA;
      D_DIV_A: if (div_done) state_d = D_DIV_B;
      D_DIV_B: if (div_done) state_d = D_DIV_C;
      D_DIV_C: if (div_done) state_d = D_VA;
      D_VA:    state_d = D_VB;
      D_VB:    state_d = D_PA;
      D_PA:    state_d = D_PB;
      D_PB:    state_d = D_IDLE;
      default: state_d = D_IDLE;
    endcase
    if (cfg_wr) state_d = D_MUL;
  end

  always_comb begin
    div_start = 1'b0;
    div_dvd   = DVW'(vv_q);
    div_dsr   = amax_q;
    unique case (state_q)
      D_CMP: begin
        div_start = !any_zero && !cfg_wr;
        div_dvd   = tri_c ? (DVW'(len_q) << (2 * FRACTION_BITS))
                          : (DVW'(vmax_q) << FRACTION_BITS);
      end
      D_DIV_A: begin
        div_start = div_done && !cfg_wr;
      end
      D_DIV_B: begin
        div_start = div_done && !cfg_wr;
        div_dvd   = DVW'(dc) << FRACTION_BITS;
        div_dsr   = vmax_q;
      end
      default: div_start = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      len_q   <= 32'd0;
      vmax_q  <= 32'd0;
      amax_q  <= 32'd0;
      prof_q  <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_wr) begin
        prof_q <= '0;
        case (cfg.reg_index)
          REG_LENGTH: len_q  <= cfg.reg_data;
          REG_VMAX:   vmax_q <= cfg.reg_data;
          REG_AMAX:   amax_q <= cfg.reg_data;
          default:    ;
        endcase
      end else if (state_q == D_PB) begin
        prof_q.valid    <= 1'b1;
        prof_q.tri_flag <= tri_q;
        prof_q.len      <= len_q;
        prof_q.amax     <= amax_q;
        prof_q.t_acc    <= tacc_q;
        prof_q.t_tot    <= ttot_q;
        prof_q.cru_end  <= cend_q;
        prof_q.peak     <= peak_q;
        prof_q.pos0     <= mul_q >> (FRACTION_BITS + 1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      D_MUL: begin
        vv_q <= vmax_q * vmax_q;
        la_q <= len_q * amax_q;
      end
      D_CMP: tri_q <= tri_c;
      D_DIV_T: if (div_done) begin
        tovf_q   <= (div_quo >> 64) != '0;
        rad_q    <= div_quo[63:0];
        srem_q   <= 34'd0;
        root_q   <= 32'd0;
        sq_cnt_q <= 5'd0;
      end
      D_SQRT: begin
        rad_q    <= {rad_q[61:0], 2'b00};
        sq_cnt_q <= sq_cnt_q + 5'd1;
        tcru_q   <= 32'd0;
        if (sq_r >= sq_trial) begin
          srem_q <= 34'(sq_r - sq_trial);
          root_q <= {root_q[30:0], 1'b1};
          tacc_q <= tovf_q ? MAX32 : {root_q[30:0], 1'b1};
        end else begin
          srem_q <= sq_r[33:0];
          root_q <= {root_q[30:0], 1'b0};
          tacc_q <= tovf_q ? MAX32 : {root_q[30:0], 1'b0};
        end
      end
      D_DIV_A: if (div_done) tacc_q <= quo_sat;
      D_DIV_C: if (div_done) tcru_q <= quo_sat;
      D_VA: mul_q <= amax_q * tacc_q;
      D_VB: begin
        va_q   <= va_c;
        peak_q <= (tri_q && va_c < vmax_q) ? va_c : vmax_q;
        ttot_q <= (tot_sum[33:32] != 2'b00) ? MAX32 : tot_sum[31:0];
        cend_q <= {1'b0, tacc_q} + {1'b0, tcru_q};
      end
      D_PA: mul_q <= va_q * tacc_q;
      default: ;
    endcase
  end

  tmprof_div #(.DVW(DVW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign busy_o = state_q != D_IDLE;
  assign prof_o = prof_q;
endmodule
`default_nettype wire

/* src/tmprof_eval.sv */
// Five-stage sample pipeline: phase select, two multiplies, position and clamp.
`default_nettype none
module tmprof_eval import tmprof_pkg::*; #(
  parameter int FRACTION_BITS = FRAC_BITS_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          busy_i,
  input  wire tmprof_prof_t  prof_i,
  tmprof_sample_if.sink      sample,
  tmprof_result_if.source    result
);
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic en1, en2, en3, en4, en5;

  tmprof_phase_e ph1_q, ph2_q, ph3_q, ph4_q, ph1_d;
  tmprof_acode_e ac1_q, ac2_q, ac3_q, ac4_q, ac1_d;
  logic [31:0] x1_q, x2_q, x3_q, x1_d;
  logic [63:0] p2_q, term3_q, w4_q;
  logic [31:0] vel3_q, vel4_q;

  logic [31:0] t;
  logic [63:0] sh3, pacc, pdec;
  logic [64:0] pcru;
  logic [31:0] pos5;

  logic        [31:0] pos_q, vel_q, ttot_q, peak_q;
  logic signed [32:0] acc_q;
  logic               tri_q, pv_q;

  assign en5 = !v5_q || result.ready;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign sample.ready = en1 && !busy_i;

  assign t = sample.sample_time;

  always_comb begin
    x1_d = t;
    if (t < prof_i.t_acc) ac1_d = AC_POS;
    else if ({1'b0, t} < prof_i.cru_end) ac1_d = AC_NONE;
    else ac1_d = AC_NEG;
    if (!prof_i.valid || t == 32'd0) begin
      ph1_d = PH_ZERO;
    end else if (t >= prof_i.t_tot) begin
      ph1_d = PH_DONE;
    end else if (t <= prof_i.t_acc) begin
      ph1_d = PH_ACC;
    end else if ({1'b0, t} <= prof_i.cru_end) begin
      ph1_d = PH_CRU;
      x1_d  = t - prof_i.t_acc;
    end else begin
      ph1_d = PH_DEC;
      x1_d  = prof_i.t_tot - t;
    end
  end

  assign sh3  = p2_q >> FRACTION_BITS;
  assign pacc = w4_q >> (FRACTION_BITS + 1);
  assign pdec = w4_q >> (FRACTION_BITS + 1);
  assign pcru = {1'b0, prof_i.pos0} + {1'b0, w4_q};

  always_comb begin
    case (ph4_q)
      PH_DONE: pos5 = prof_i.len;
      PH_ACC:  pos5 = (pacc > {32'd0, prof_i.len}) ? prof_i.len : pacc[31:0];
      PH_CRU:  pos5 = (pcru > {33'd0, prof_i.len}) ? prof_i.len : pcru[31:0];
      PH_DEC:  pos5 = (pdec >= {32'd0, prof_i.len}) ? 32'd0 : prof_i.len - pdec[31:0];
      default: pos5 = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en1) v1_q <= sample.valid && sample.ready;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      ph1_q <= ph1_d;
      ac1_q <= ac1_d;
      x1_q  <= x1_d;
    end
    if (en2) begin
      ph2_q <= ph1_q;
      ac2_q <= ac1_q;
      x2_q  <= x1_q;
      p2_q  <= ((ph1_q == PH_CRU) ? prof_i.peak : prof_i.amax) * x1_q;
    end
    if (en3) begin
      ph3_q   <= ph2_q;
      ac3_q   <= ac2_q;
      x3_q    <= x2_q;
      term3_q <= sh3;
      vel3_q  <= (ph2_q == PH_CRU) ? prof_i.peak : sat32(sh3);
    end
    if (en4) begin
      ph4_q  <= ph3_q;
      ac4_q  <= ac3_q;
      vel4_q <= vel3_q;
      w4_q   <= (ph3_q == PH_CRU) ? term3_q : vel3_q * x3_q;
    end
    if (en5) begin
      pos_q  <= pos5;
      vel_q  <= (ph4_q == PH_ACC || ph4_q == PH_CRU || ph4_q == PH_DEC) ? vel4_q : 32'd0;
      ttot_q <= prof_i.valid ? prof_i.t_tot : 32'd0;
      peak_q <= prof_i.valid ? prof_i.peak : 32'd0;
      tri_q  <= prof_i.valid && prof_i.tri_flag;
      pv_q   <= prof_i.valid;
      if (ph4_q == PH_ZERO || ph4_q == PH_DONE) acc_q <= 33'sd0;
      else begin
        case (ac4_q)
          AC_POS:  acc_q <= signed'({1'b0, prof_i.amax});
          AC_NEG:  acc_q <= -signed'({1'b0, prof_i.amax});
          default: acc_q <= 33'sd0;
        endcase
      end
    end
  end

  assign result.valid         = v5_q;
  assign result.position      = pos_q;
  assign result.velocity      = vel_q;
  assign result.acceleration  = acc_q;
  assign result.total_time    = ttot_q;
  assign result.peak_velocity = peak_q;
  assign result.is_triangular = tri_q;
  assign result.profile_valid = pv_q;
endmodule
`default_nettype wire

/* src/trapezoidal_motion_profile.sv */
// Top level of the trapezoidal motion profile evaluator.
// Samples stream through a five-stage pipeline at one word per cycle unless
// the result side stalls or the timings are being derived; the fifth stage is
// the result register. After any configuration write the timings are recomputed
// by a sequencer around one shift divider (one quotient bit per cycle) and a
// two-bit-per-cycle square root, with a divider length of the larger of 64 and
// 32 + 2*FRACTION_BITS. Samples are held off while it runs: one division and the
// root on a triangular profile, three divisions on a trapezoid.
`default_nettype none
module trapezoidal_motion_profile import tmprof_pkg::*; #(
  parameter int FRACTION_BITS = FRAC_BITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  tmprof_cfg_if.sink       cfg_i,
  tmprof_sample_if.sink    sample_i,
  tmprof_result_if.source  result_o
);
  logic         busy;
  tmprof_prof_t prof;

  tmprof_derive #(.FRACTION_BITS(FRACTION_BITS)) u_derive (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg    (cfg_i),
    .busy_o (busy),
    .prof_o (prof)
  );

  tmprof_eval #(.FRACTION_BITS(FRACTION_BITS)) u_eval (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .busy_i (busy),
    .prof_i (prof),
    .sample (sample_i),
    .result (result_o)
  );
endmodule
`default_nettype wire
